@@ hw/rtl/twt_pkg.sv @@
// ----------------------------------------------------------------------------
// twt_pkg
// Types, field codes and token expansion helpers shared by the TWT action
// frame parser.
// ----------------------------------------------------------------------------
package twt_pkg;

    // Input byte and output token payloads
    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
    } in_item_t;

    typedef struct packed {
        logic [4:0]  field_code;
        logic [63:0] field_value;
        logic        last_of_byte;
        logic        frame_done;
        logic        status;
    } out_item_t;

    // Field codes
    localparam logic [4:0] FC_CATEGORY    = 5'd0;
    localparam logic [4:0] FC_ACTION      = 5'd1;
    localparam logic [4:0] FC_DIALOG      = 5'd2;
    localparam logic [4:0] FC_ELEMENT_ID  = 5'd3;
    localparam logic [4:0] FC_LENGTH      = 5'd4;
    localparam logic [4:0] FC_NDP_IND     = 5'd5;
    localparam logic [4:0] FC_PM_MODE     = 5'd6;
    localparam logic [4:0] FC_REQUEST     = 5'd7;
    localparam logic [4:0] FC_SETUP_CMD   = 5'd8;
    localparam logic [4:0] FC_IMPLICIT    = 5'd9;
    localparam logic [4:0] FC_ANNOUNCED   = 5'd10;
    localparam logic [4:0] FC_FLOW_ID     = 5'd11;
    localparam logic [4:0] FC_WI_EXP      = 5'd12;
    localparam logic [4:0] FC_PROTECTED   = 5'd13;
    localparam logic [4:0] FC_WAKE_TIME   = 5'd14;
    localparam logic [4:0] FC_GROUP_ID    = 5'd15;
    localparam logic [4:0] FC_ZO_PRESENT  = 5'd16;
    localparam logic [4:0] FC_ZERO_OFFSET = 5'd17;
    localparam logic [4:0] FC_TIME_UNIT   = 5'd18;
    localparam logic [4:0] FC_GROUP_OFS   = 5'd19;
    localparam logic [4:0] FC_MIN_WAKE    = 5'd20;
    localparam logic [4:0] FC_WI_MANT     = 5'd21;
    localparam logic [4:0] FC_CHANNEL     = 5'd22;
    localparam logic [4:0] FC_NDP_ID      = 5'd23;
    localparam logic [4:0] FC_MAX_PAGING  = 5'd24;
    localparam logic [4:0] FC_PTSF_OFS    = 5'd25;
    localparam logic [4:0] FC_PAGING_ACT  = 5'd26;
    localparam logic [4:0] FC_MIN_SLEEP   = 5'd27;

    // Burst kinds: how one byte's record expands into tokens
    localparam logic [2:0] OP_SINGLE = 3'd0;
    localparam logic [2:0] OP_CTRL   = 3'd1;
    localparam logic [2:0] OP_REQ    = 3'd2;
    localparam logic [2:0] OP_GROUP  = 3'd3;
    localparam logic [2:0] OP_TUNIT  = 3'd4;
    localparam logic [2:0] OP_PAGING = 3'd5;

    // Frame kinds
    localparam logic [1:0] KIND_IDLE     = 2'd0;
    localparam logic [1:0] KIND_SETUP    = 2'd1;
    localparam logic [1:0] KIND_TEARDOWN = 2'd2;

    // Configuration register indexes
    localparam logic REG_SETUP_CODE    = 1'b0;
    localparam logic REG_TEARDOWN_CODE = 1'b1;

    // Queue between front and back
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    typedef struct packed {
        logic [2:0]  op;
        logic [4:0]  code;
        logic [63:0] value;
        logic        done;
        logic        status;
    } rec_t;

    // Number of tokens minus one for a burst kind
    function automatic logic [2:0] op_last_idx(input logic [2:0] op);
        logic [2:0] r;
        case (op)
            OP_SINGLE: r = 3'd0;
            OP_CTRL:   r = 3'd1;
            OP_REQ:    r = 3'd6;
            OP_GROUP:  r = 3'd1;
            OP_TUNIT:  r = 3'd1;
            OP_PAGING: r = 3'd4;
            default:   r = 3'd0;
        endcase
        return r;
    endfunction

endpackage

@@ hw/rtl/twt_queue.sv @@
// ----------------------------------------------------------------------------
// twt_queue
// Short register FIFO of byte records between the front and back parts.
// ----------------------------------------------------------------------------
module twt_queue
    import twt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  rec_t push_data,
    input  logic pop,
    output rec_t pop_data,
    output logic empty,
    output logic full
);

    rec_t             mem_reg [QDEPTH];
    logic [QAW-1:0]   wr_ptr_reg;
    logic [QAW-1:0]   wr_ptr_next;
    logic [QAW-1:0]   rd_ptr_reg;
    logic [QAW-1:0]   rd_ptr_next;
    logic [QAW:0]     count_reg;
    logic [QAW:0]     count_next;
    logic             do_push;
    logic             do_pop;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == QAW'(0) + (QAW+1)'(QDEPTH));
    assign pop_data = mem_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ hw/rtl/twt_front.sv @@
// ----------------------------------------------------------------------------
// twt_front
// Tracks frame position and classifies bytes into token burst records; bytes of multi-byte fields are gathered first.
// ----------------------------------------------------------------------------
module twt_front
    import twt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] setup_code,
    input  logic [7:0] teardown_code,
    input  logic       accept,
    input  in_item_t   item,
    output logic       push,
    output rec_t       rec
);

    logic [5:0]  pos_reg;
    logic [5:0]  pos_next;
    logic [1:0]  kind_reg;
    logic [1:0]  kind_next;
    logic        paging_reg;
    logic        paging_next;
    logic        offset_reg;
    logic        offset_next;
    logic [63:0] acc_reg;
    logic [63:0] acc_next;
    logic        complete_reg;
    logic        complete_next;

    always_comb
    begin
        logic [7:0]  b;
        logic [6:0]  q;
        logic        done;
        logic [47:0] zo;

        b             = item.data_byte;
        q             = {1'b0, pos_reg};
        done          = 1'b0;
        zo            = '0;
        pos_next      = pos_reg;
        kind_next     = kind_reg;
        paging_next   = paging_reg;
        offset_next   = offset_reg;
        acc_next      = acc_reg;
        complete_next = complete_reg;
        push          = 1'b0;
        rec.op        = OP_SINGLE;
        rec.code      = FC_CATEGORY;
        rec.value     = {56'd0, b};
        rec.done      = 1'b0;
        rec.status    = 1'b0;

        if (!accept)
        begin
            push = 1'b0;
        end
        else if (item.frame_start)
        begin
            complete_next = 1'b0;
            kind_next     = KIND_IDLE;
            paging_next   = 1'b0;
            offset_next   = 1'b0;
            acc_next      = '0;
            pos_next      = 6'd1;
            push          = 1'b1;
        end
        else if (!complete_reg)
        begin
            if (pos_reg == 6'd1)
            begin
                push     = 1'b1;
                rec.code = FC_ACTION;
                if (b == setup_code)
                begin
                    kind_next = KIND_SETUP;
                end
                else if (b == teardown_code)
                begin
                    kind_next = KIND_TEARDOWN;
                end
                else
                begin
                    rec.status = 1'b1;
                    done       = 1'b1;
                end
            end
            else if (kind_reg == KIND_TEARDOWN)
            begin
                push      = 1'b1;
                rec.code  = FC_FLOW_ID;
                rec.value = {61'd0, b[7:5]};
                done      = 1'b1;
            end
            else if (kind_reg == KIND_SETUP)
            begin
                // skip the zero offset bytes when the group says it is absent
                if (q >= 7'd17 && !offset_reg)
                begin
                    q = q + 7'd6;
                end
                case (q)
                    7'd2, 7'd3, 7'd4:
                    begin
                        push     = 1'b1;
                        rec.code = q[4:0];
                    end
                    7'd5:
                    begin
                        paging_next = b[7];
                        push        = 1'b1;
                        rec.op      = OP_CTRL;
                    end
                    7'd6, 7'd23, 7'd26:
                    begin
                        acc_next = {56'd0, b};
                    end
                    7'd7:
                    begin
                        push      = 1'b1;
                        rec.op    = OP_REQ;
                        rec.value = {48'd0, b, acc_reg[7:0]};
                    end
                    7'd8, 7'd9, 7'd10, 7'd11, 7'd12, 7'd13, 7'd14, 7'd15:
                    begin
                        acc_next = {(q == 7'd8) ? 56'd0 : acc_reg[55:0], b};
                        if (q == 7'd15)
                        begin
                            push      = 1'b1;
                            rec.code  = FC_WAKE_TIME;
                            rec.value = acc_next;
                        end
                    end
                    7'd16:
                    begin
                        offset_next = b[0];
                        push        = 1'b1;
                        rec.op      = OP_GROUP;
                    end
                    7'd17, 7'd18, 7'd19, 7'd20, 7'd21, 7'd22:
                    begin
                        acc_next = {(q == 7'd17) ? 56'd0 : acc_reg[55:0], b};
                        if (q == 7'd22)
                        begin
                            zo        = acc_next[47:0];
                            push      = 1'b1;
                            rec.code  = FC_ZERO_OFFSET;
                            rec.value = {16'd0, zo[15:0], zo[47:16]};
                        end
                    end
                    7'd24:
                    begin
                        push      = 1'b1;
                        rec.op    = OP_TUNIT;
                        rec.value = {48'd0, b, acc_reg[7:0]};
                    end
                    7'd25:
                    begin
                        push     = 1'b1;
                        rec.code = FC_MIN_WAKE;
                    end
                    7'd27:
                    begin
                        push      = 1'b1;
                        rec.code  = FC_WI_MANT;
                        rec.value = {48'd0, acc_reg[7:0], b};
                    end
                    7'd28:
                    begin
                        push     = 1'b1;
                        rec.code = FC_CHANNEL;
                        done     = !paging_reg;
                    end
                    7'd29:
                    begin
                        acc_next = {56'd0, b};
                    end
                    7'd30:
                    begin
                        acc_next[15:8] = b;
                    end
                    7'd31:
                    begin
                        acc_next[23:16] = b;
                    end
                    7'd32:
                    begin
                        acc_next[31:24] = b;
                        push      = 1'b1;
                        rec.op    = OP_PAGING;
                        rec.value = {32'd0, acc_next[31:0]};
                        done      = 1'b1;
                    end
                    default:
                    begin
                        done = 1'b1;
                    end
                endcase
            end
            else
            begin
                done = 1'b1;
            end
            pos_next = pos_reg + 6'd1;
            if (done)
            begin
                complete_next = 1'b1;
                kind_next     = KIND_IDLE;
            end
        end
        rec.done = done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            kind_reg     <= KIND_IDLE;
            paging_reg   <= 1'b0;
            offset_reg   <= 1'b0;
            acc_reg      <= '0;
            complete_reg <= 1'b1;
        end
        else
        begin
            pos_reg      <= pos_next;
            kind_reg     <= kind_next;
            paging_reg   <= paging_next;
            offset_reg   <= offset_next;
            acc_reg      <= acc_next;
            complete_reg <= complete_next;
        end
    end

endmodule

@@ hw/rtl/twt_back.sv @@
// ----------------------------------------------------------------------------
// twt_back
// Expands queued byte records into field tokens, one token per cycle while the
// output is not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
module twt_back
    import twt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_empty,
    input  rec_t      q_data,
    output logic      q_pop,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    logic      cur_valid_reg;
    logic      cur_valid_next;
    rec_t      cur_reg;
    logic [2:0] idx_reg;
    logic [2:0] idx_next;
    logic      out_valid_reg;
    logic      out_valid_next;
    out_item_t out_reg;
    out_item_t tok;
    logic      emit;
    logic      last;

    assign emit = cur_valid_reg && (!out_valid_reg || out_ready);
    assign last = (idx_reg == op_last_idx(cur_reg.op));
    assign q_pop = !q_empty && (!cur_valid_reg || (emit && last));

    // Token for the current record and index
    always_comb
    begin
        logic [63:0] v;

        v                = cur_reg.value;
        tok.field_code   = cur_reg.code;
        tok.field_value  = v;
        tok.last_of_byte = last;
        tok.frame_done   = last && cur_reg.done;
        tok.status       = cur_reg.status;
        case (cur_reg.op)
            OP_CTRL:
            begin
                tok.field_code  = (idx_reg == 3'd0) ? FC_NDP_IND : FC_PM_MODE;
                tok.field_value = {63'd0, (idx_reg == 3'd0) ? v[7] : v[6]};
            end
            OP_REQ:
            begin
                case (idx_reg)
                    3'd0:
                    begin
                        tok.field_code  = FC_REQUEST;
                        tok.field_value = {63'd0, v[15]};
                    end
                    3'd1:
                    begin
                        tok.field_code  = FC_SETUP_CMD;
                        tok.field_value = {61'd0, v[14:12]};
                    end
                    3'd2:
                    begin
                        tok.field_code  = FC_IMPLICIT;
                        tok.field_value = {63'd0, v[10]};
                    end
                    3'd3:
                    begin
                        tok.field_code  = FC_ANNOUNCED;
                        tok.field_value = {63'd0, ~v[9]};
                    end
                    3'd4:
                    begin
                        tok.field_code  = FC_FLOW_ID;
                        tok.field_value = {61'd0, v[8:6]};
                    end
                    3'd5:
                    begin
                        tok.field_code  = FC_WI_EXP;
                        tok.field_value = {59'd0, v[5:1]};
                    end
                    default:
                    begin
                        tok.field_code  = FC_PROTECTED;
                        tok.field_value = {63'd0, v[0]};
                    end
                endcase
            end
            OP_GROUP:
            begin
                if (idx_reg == 3'd0)
                begin
                    tok.field_code  = FC_GROUP_ID;
                    tok.field_value = {57'd0, v[7:1]};
                end
                else
                begin
                    tok.field_code  = FC_ZO_PRESENT;
                    tok.field_value = {63'd0, v[0]};
                end
            end
            OP_TUNIT:
            begin
                if (idx_reg == 3'd0)
                begin
                    tok.field_code  = FC_TIME_UNIT;
                    tok.field_value = {60'd0, v[15:12]};
                end
                else
                begin
                    tok.field_code  = FC_GROUP_OFS;
                    tok.field_value = {52'd0, v[11:0]};
                end
            end
            OP_PAGING:
            begin
                case (idx_reg)
                    3'd0:
                    begin
                        tok.field_code  = FC_NDP_ID;
                        tok.field_value = {55'd0, v[31:23]};
                    end
                    3'd1:
                    begin
                        tok.field_code  = FC_MAX_PAGING;
                        tok.field_value = {56'd0, v[22:15]};
                    end
                    3'd2:
                    begin
                        tok.field_code  = FC_PTSF_OFS;
                        tok.field_value = {60'd0, v[14:11]};
                    end
                    3'd3:
                    begin
                        tok.field_code  = FC_PAGING_ACT;
                        tok.field_value = {61'd0, v[10:8]};
                    end
                    default:
                    begin
                        tok.field_code  = FC_MIN_SLEEP;
                        tok.field_value = {58'd0, v[7:2]};
                    end
                endcase
            end
            default:
            begin
                tok.field_code = cur_reg.code;
            end
        endcase
    end

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        if (emit)
        begin
            idx_next = idx_reg + 3'd1;
            if (last)
            begin
                cur_valid_next = 1'b0;
                idx_next       = '0;
            end
        end
        if (q_pop)
        begin
            cur_valid_next = 1'b1;
            idx_next       = '0;
        end
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_data;
        end
        if (emit)
        begin
            out_reg <= tok;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

@@ hw/rtl/twt_action_frame_parser.sv @@
// ----------------------------------------------------------------------------
// twt_action_frame_parser
// Target wake time action frame parser: bytes in, decoded field tokens out.
// ----------------------------------------------------------------------------
// Path: a byte's record goes through the record queue, the current record
// register and the output register. Throughput: one byte per cycle while the
// queue is not full; the token stage emits one token per cycle unless out_ready
// holds it; a byte yields at most 7 tokens and the 4-entry queue absorbs bursts.
// Reset: asynchronous active low; parser waits for a frame start byte and the
// action codes return to 6 (setup) and 7 (teardown).
module twt_action_frame_parser
    import twt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0] setup_code_reg;
    logic [7:0] setup_code_next;
    logic [7:0] teardown_code_reg;
    logic [7:0] teardown_code_next;
    logic       cfg_wr;
    logic       in_accept;
    logic       push;
    rec_t       push_rec;
    logic       q_pop;
    rec_t       q_data;
    logic       q_empty;
    logic       q_full;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        setup_code_next    = setup_code_reg;
        teardown_code_next = teardown_code_reg;
        if (cfg_wr)
        begin
            case (paddr[2])
                REG_SETUP_CODE:    setup_code_next    = pwdata[7:0];
                REG_TEARDOWN_CODE: teardown_code_next = pwdata[7:0];
                default:           setup_code_next    = setup_code_reg;
            endcase
        end
        prdata = {24'd0, (paddr[2] == REG_TEARDOWN_CODE) ? teardown_code_reg
                                                         : setup_code_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setup_code_reg    <= 8'd6;
            teardown_code_reg <= 8'd7;
        end
        else
        begin
            setup_code_reg    <= setup_code_next;
            teardown_code_reg <= teardown_code_next;
        end
    end

    assign in_ready  = !q_full;
    assign in_accept = in_valid && in_ready;

    twt_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .setup_code    (setup_code_reg),
        .teardown_code (teardown_code_reg),
        .accept        (in_accept),
        .item          (in_data),
        .push          (push),
        .rec           (push_rec)
    );

    twt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_rec),
        .pop       (q_pop),
        .pop_data  (q_data),
        .empty     (q_empty),
        .full      (q_full)
    );

    twt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_data    (q_data),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
